FILE: rtl/rti_pkg.sv
// Shared widths, register indexes and payload types for the ray/triangle tester.
`timescale 1ns / 1ps
package rti_pkg;

  localparam int CW = 16;          // coordinate width, signed Q8.8
  localparam int TW = 32;          // ray parameter width, signed Q16.16
  localparam int TF = 16;          // fraction bits of the ray parameter
  localparam int VW = 3 * CW;      // packed x,y,z vector width
  localparam int DIV_STAGES = TW;  // one quotient bit per stage
  localparam int NW = 33;          // magnitude of the numerator
  localparam int MW = 32;          // magnitude of the denominator
  localparam int PRW = CW + TW;    // t times a direction component
  localparam int PW = 41;          // hit point coordinate, 16 fraction bits
  localparam int DW = PW + 1;      // hit point minus vertex
  localparam int EW = DW + CW;     // one edge product term
  localparam int SW = EW + 2;      // sum of an edge's x, y and z terms

  localparam logic [3:0] REG_PLANE_NORMAL = 4'd0;
  localparam logic [3:0] REG_PLANE_OFFSET = 4'd1;
  localparam logic [3:0] REG_VERTEX_A     = 4'd2;
  localparam logic [3:0] REG_VERTEX_B     = 4'd3;
  localparam logic [3:0] REG_VERTEX_C     = 4'd4;
  localparam logic [3:0] REG_INWARD_AB    = 4'd5;
  localparam logic [3:0] REG_INWARD_BC    = 4'd6;
  localparam logic [3:0] REG_INWARD_CA    = 4'd7;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [TW-1:0] tpar_t;

  typedef struct packed {
    coord_t ox;
    coord_t oy;
    coord_t oz;
    coord_t dx;
    coord_t dy;
    coord_t dz;
    tpar_t  tmin;
    tpar_t  tmax;
  } ray_t;

  typedef struct packed {
    logic          valid;
    ray_t          ray;
    logic          face;
    logic          ovf;
    logic          neg;
    logic [NW-1:0] n;
    logic [MW-1:0] m;
    logic [MW-1:0] rem;
    logic [TW-1:0] q;
  } div_t;

  // Signed component k of a packed x,y,z vector, x in the low bits.
  function automatic coord_t comp(input logic [VW-1:0] v, input logic [1:0] k);
    comp = v[k*CW +: CW];
  endfunction

endpackage

FILE: rtl/ray_triangle_intersect.sv
// Pipelined fixed-point ray versus triangle intersection test.
`timescale 1ns / 1ps
// The block tests one ray against the triangle held in its configuration registers and
// returns one result per ray: a hit flag and the ray parameter t (zero on a miss). It takes
// one ray per clock cycle as long as results are taken. Most of the pipeline is the
// restoring divider that forms t = (offset - normal.origin) / (normal.dir), which
// resolves one quotient bit per pipeline stage over 32 stages; the remaining stages hold
// the dot-product multipliers, the saturation and bounds check, the hit-point multiplier
// and the tests of edges AB, BC and CA. All stages advance together; when the output
// register holds a result that has not been taken, the whole pipeline holds and in_ready
// drops, so nothing is lost or repeated.
// Configuration writes are registered and must only happen while no ray is in flight.
module ray_triangle_intersect (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [15:0]     in_origin_x,
  input  logic signed [15:0]     in_origin_y,
  input  logic signed [15:0]     in_origin_z,
  input  logic signed [15:0]     in_dir_x,
  input  logic signed [15:0]     in_dir_y,
  input  logic signed [15:0]     in_dir_z,
  input  logic signed [31:0]     in_t_min,
  input  logic signed [31:0]     in_t_max,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_hit,
  output logic signed [31:0]     out_t_hit,
  input  logic                   cfg_we,
  input  logic [3:0]             cfg_index,
  input  logic [47:0]            cfg_wdata
);

  // Configuration registers.
  logic [rti_pkg::VW-1:0] normal_r;
  rti_pkg::tpar_t         offset_r;
  logic [rti_pkg::VW-1:0] vert_r [3];
  logic [rti_pkg::VW-1:0] inw_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_r <= '0;
      offset_r <= '0;
      for (int k = 0; k < 3; k++) begin
        vert_r[k] <= '0;
        inw_r[k]  <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        rti_pkg::REG_PLANE_NORMAL: normal_r  <= cfg_wdata;
        rti_pkg::REG_PLANE_OFFSET: offset_r  <= cfg_wdata[rti_pkg::TW-1:0];
        rti_pkg::REG_VERTEX_A:     vert_r[0] <= cfg_wdata;
        rti_pkg::REG_VERTEX_B:     vert_r[1] <= cfg_wdata;
        rti_pkg::REG_VERTEX_C:     vert_r[2] <= cfg_wdata;
        rti_pkg::REG_INWARD_AB:    inw_r[0]  <= cfg_wdata;
        rti_pkg::REG_INWARD_BC:    inw_r[1]  <= cfg_wdata;
        rti_pkg::REG_INWARD_CA:    inw_r[2]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves when the output register is empty or being drained.
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  rti_pkg::ray_t in_ray;
  assign in_ray = '{ox: in_origin_x, oy: in_origin_y, oz: in_origin_z,
                    dx: in_dir_x, dy: in_dir_y, dz: in_dir_z,
                    tmin: in_t_min, tmax: in_t_max};

  // Stage 1: the six normal products.
  logic                 s1_v_r;
  rti_pkg::ray_t        s1_ray_r;
  logic signed [31:0]   s1_nd_r [3];
  logic signed [31:0]   s1_no_r [3];
  logic signed [31:0]   s1_nd_nxt [3];
  logic signed [31:0]   s1_no_nxt [3];

  always_comb begin
    rti_pkg::coord_t nk;
    rti_pkg::coord_t dk [3];
    rti_pkg::coord_t ok [3];
    dk[0] = in_ray.dx; dk[1] = in_ray.dy; dk[2] = in_ray.dz;
    ok[0] = in_ray.ox; ok[1] = in_ray.oy; ok[2] = in_ray.oz;
    for (int k = 0; k < 3; k++) begin
      nk = rti_pkg::comp(normal_r, 2'(k));
      s1_nd_nxt[k] = 32'(nk) * 32'(dk[k]);
      s1_no_nxt[k] = 32'(nk) * 32'(ok[k]);
    end
  end

  // Stage 2: denominator and numerator sums, signs and magnitudes.
  rti_pkg::div_t dv_r   [rti_pkg::DIV_STAGES+1];
  rti_pkg::div_t dv_nxt [rti_pkg::DIV_STAGES+1];

  always_comb begin
    logic signed [33:0] l;
    logic signed [34:0] num;
    logic [34:0]        mag;
    l   = 34'(s1_nd_r[0]) + 34'(s1_nd_r[1]) + 34'(s1_nd_r[2]);
    num = 35'(offset_r) - 35'(s1_no_r[0]) - 35'(s1_no_r[1]) - 35'(s1_no_r[2]);
    mag = num[34] ? 35'(-num) : 35'(num);
    dv_nxt[0]       = '0;
    dv_nxt[0].valid = s1_v_r;
    dv_nxt[0].ray   = s1_ray_r;
    dv_nxt[0].face  = l[33];
    dv_nxt[0].neg   = num[34];
    dv_nxt[0].n     = mag[rti_pkg::NW-1:0];
    dv_nxt[0].m     = l[33] ? 32'(-l) : 32'd1;
    dv_nxt[0].ovf   = 32'(mag[rti_pkg::NW-1:rti_pkg::TF]) >= dv_nxt[0].m;
    dv_nxt[0].rem   = 32'(mag[rti_pkg::NW-1:rti_pkg::TF]);
    // Restoring division of n * 2^16 by m, one quotient bit per stage, MSB first.
    for (int j = 0; j < rti_pkg::DIV_STAGES; j++) begin
      logic [rti_pkg::NW+rti_pkg::TF-1:0] nn;
      logic [rti_pkg::MW:0]               rem2;
      logic                               ge;
      nn   = {dv_r[j].n, {rti_pkg::TF{1'b0}}};
      rem2 = {dv_r[j].rem, nn[rti_pkg::DIV_STAGES-1-j]};
      ge   = rem2 >= {1'b0, dv_r[j].m};
      dv_nxt[j+1]     = dv_r[j];
      dv_nxt[j+1].rem = ge ? 32'(rem2 - {1'b0, dv_r[j].m}) : rem2[rti_pkg::MW-1:0];
      dv_nxt[j+1].q[rti_pkg::DIV_STAGES-1-j] = ge;
    end
  end

  // Stage T: sign, saturation and the exclusive bounds test.
  logic            st_v_r, st_ok_r;
  rti_pkg::ray_t   st_ray_r;
  rti_pkg::tpar_t  st_t_r;
  rti_pkg::tpar_t  st_t_nxt;
  logic            st_ok_nxt;

  always_comb begin
    logic              sat;
    rti_pkg::div_t     dq;
    dq  = dv_r[rti_pkg::DIV_STAGES];
    sat = dq.ovf || dq.q[rti_pkg::TW-1];
    if (dq.neg) begin
      st_t_nxt = sat ? {1'b0, {(rti_pkg::TW-1){1'b1}}} : rti_pkg::tpar_t'(dq.q);
    end else begin
      st_t_nxt = sat ? {1'b1, {(rti_pkg::TW-1){1'b0}}} : rti_pkg::tpar_t'(-dq.q);
    end
    st_ok_nxt = dq.face && (dq.ray.tmin < st_t_nxt) && (st_t_nxt < dq.ray.tmax);
  end

  // Stage M: t times each direction component.
  logic                              sm_v_r, sm_ok_r;
  rti_pkg::ray_t                     sm_ray_r;
  rti_pkg::tpar_t                    sm_t_r;
  logic signed [rti_pkg::PRW-1:0]    sm_prod_r [3];
  logic signed [rti_pkg::PRW-1:0]    sm_prod_nxt [3];

  always_comb begin
    sm_prod_nxt[0] = rti_pkg::PRW'(st_t_r) * rti_pkg::PRW'(st_ray_r.dx);
    sm_prod_nxt[1] = rti_pkg::PRW'(st_t_r) * rti_pkg::PRW'(st_ray_r.dy);
    sm_prod_nxt[2] = rti_pkg::PRW'(st_t_r) * rti_pkg::PRW'(st_ray_r.dz);
  end

  // Stage P: hit point with 16 fraction bits, t*dir rounded toward minus infinity.
  logic                           sp_v_r, sp_ok_r;
  rti_pkg::tpar_t                 sp_t_r;
  logic signed [rti_pkg::PW-1:0]  sp_p_r [3];
  logic signed [rti_pkg::PW-1:0]  sp_p_nxt [3];

  always_comb begin
    rti_pkg::coord_t ok [3];
    ok[0] = sm_ray_r.ox; ok[1] = sm_ray_r.oy; ok[2] = sm_ray_r.oz;
    for (int k = 0; k < 3; k++) begin
      sp_p_nxt[k] = (rti_pkg::PW'(ok[k]) <<< 8) + rti_pkg::PW'(sm_prod_r[k] >>> 8);
    end
  end

  // Stage E: the edge product terms, one per edge and axis.
  logic                           se_v_r, se_ok_r;
  rti_pkg::tpar_t                 se_t_r;
  logic signed [rti_pkg::EW-1:0]  se_e_r   [3][3];
  logic signed [rti_pkg::EW-1:0]  se_e_nxt [3][3];

  always_comb begin
    logic signed [rti_pkg::DW-1:0] diff;
    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 3; k++) begin
        diff = rti_pkg::DW'(sp_p_r[k])
             - (rti_pkg::DW'(rti_pkg::comp(vert_r[e], 2'(k))) <<< 8);
        se_e_nxt[e][k] = rti_pkg::EW'(diff) * rti_pkg::EW'(rti_pkg::comp(inw_r[e], 2'(k)));
      end
    end
  end

  // Stage S: strict edge tests and the final result.
  logic out_hit_nxt;
  always_comb begin
    logic signed [rti_pkg::SW-1:0] s;
    out_hit_nxt = se_ok_r;
    for (int e = 0; e < 3; e++) begin
      s = rti_pkg::SW'(se_e_r[e][0]) + rti_pkg::SW'(se_e_r[e][1])
        + rti_pkg::SW'(se_e_r[e][2]);
      if (s <= 0) begin
        out_hit_nxt = 1'b0;
      end
    end
  end

  logic           out_hit_r;
  rti_pkg::tpar_t out_t_r;

  // Valid bits, and the divider stages whose valid bits travel inside them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      st_v_r      <= 1'b0;
      sm_v_r      <= 1'b0;
      sp_v_r      <= 1'b0;
      se_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j <= rti_pkg::DIV_STAGES; j++) begin
        dv_r[j].valid <= 1'b0;
      end
    end else if (adv) begin
      s1_v_r      <= in_valid;
      for (int j = 0; j <= rti_pkg::DIV_STAGES; j++) begin
        dv_r[j] <= dv_nxt[j];
      end
      st_v_r      <= dv_r[rti_pkg::DIV_STAGES].valid;
      sm_v_r      <= st_v_r;
      sp_v_r      <= sm_v_r;
      se_v_r      <= sp_v_r;
      out_valid_r <= se_v_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ray_r <= in_ray;
      s1_nd_r  <= s1_nd_nxt;
      s1_no_r  <= s1_no_nxt;
      st_ray_r  <= dv_r[rti_pkg::DIV_STAGES].ray;
      st_t_r    <= st_t_nxt;
      st_ok_r   <= st_ok_nxt;
      sm_ray_r  <= st_ray_r;
      sm_t_r    <= st_t_r;
      sm_ok_r   <= st_ok_r;
      sm_prod_r <= sm_prod_nxt;
      sp_t_r    <= sm_t_r;
      sp_ok_r   <= sm_ok_r;
      sp_p_r    <= sp_p_nxt;
      se_t_r    <= sp_t_r;
      se_ok_r   <= sp_ok_r;
      se_e_r    <= se_e_nxt;
      out_hit_r <= out_hit_nxt;
      out_t_r   <= out_hit_nxt ? se_t_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_t_hit = out_t_r;

endmodule

FILE: tb/tb_ray_triangle_intersect.sv
// Self-checking testbench for the pipelined ray versus triangle intersection block.
`timescale 1ns / 1ps
// The testbench streams rays into the block through the input valid/ready channel and
// checks every result transfer against a behavioral predictor of the fixed-point test.
// The predictor keeps its own mirror of the eight configuration registers. It forms the
// hit decision and the ray parameter with exact 64-bit integer math. A driver and a
// monitor, both clocked always blocks, handle the two channels with random idle gaps.
// An initial block sequences the run. It starts with a short directed part: the reset
// triangle, parallel and same-side rays, empty bounds, rays that land exactly on an edge,
// quotient saturation and the field extremes. Then come phases of random rays. Each phase
// first programs a new triangle while the block is idle. Most triangles lie in an
// axis-aligned plane, and most rays in those phases are aimed at a point of the triangle,
// so hits are frequent. Every third phase loads fully random registers, and one phase
// loads the register extremes.
module tb_ray_triangle_intersect;

  localparam int LATENCY_WAIT = 45;        // a little more than the pipeline depth
  localparam int IDLE_LIMIT = 4000;        // watchdog: cycles without any transfer
  localparam int PHASES = 10;
  localparam int RAYS_PER_PHASE = 143;
  localparam logic [3:0] REG_SPARE = 4'd8; // first index that the block ignores

  typedef struct packed {
    logic        hit;
    logic [31:0] t_hit;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [15:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [31:0] in_t_min = '0, in_t_max = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic signed [31:0] out_t_hit;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_index = '0;
  logic [47:0] cfg_wdata = '0;

  // Mirror of the triangle registers, updated when a write is driven.
  logic [47:0] tri_normal, tri_va, tri_vb, tri_vc, tri_nab, tri_nbc, tri_nca;
  logic signed [31:0] tri_offset;

  rti_pkg::ray_t pending_rays[$];
  verdict_t expected_verdicts[$];
  rti_pkg::ray_t ray_on_bus;
  int send_gap = 0;
  int take_gap = 0;
  bit calm = 1'b0;
  int errors = 0;
  int hits_seen = 0;
  int misses_seen = 0;
  int idle_cycles = 0;
  bit in_fire, out_fire;

  // Geometry of the current axis-aligned triangle, used to aim rays at it.
  int plane_axis, plane_sign, plane_level;
  int vtx[3][3];

  ray_triangle_intersect dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_origin_x(in_origin_x), .in_origin_y(in_origin_y), .in_origin_z(in_origin_z),
    .in_dir_x(in_dir_x), .in_dir_y(in_dir_y), .in_dir_z(in_dir_z),
    .in_t_min(in_t_min), .in_t_max(in_t_max),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_t_hit(out_t_hit),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic longint lane(input logic [47:0] v, input int k);
    logic signed [15:0] c;
    c = v[k*16 +: 16];
    return longint'(c);
  endfunction

  function automatic longint clip(input longint x, input longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // Signed distance of the hit point past one edge, scaled by the edge normal.
  function automatic bit edge_clear(input longint p[3], input logic [47:0] vert,
                                    input logic [47:0] nrm);
    longint s;
    s = 0;
    for (int k = 0; k < 3; k++) s += (p[k] - lane(vert, k) * 256) * lane(nrm, k);
    return s > 0;
  endfunction

  function automatic verdict_t trace_ray(input rti_pkg::ray_t r);
    verdict_t v;
    longint o[3], d[3], p[3];
    longint l, num, t, tlo, thi, hp, lp;
    longint unsigned n, m, qi, mag, half;
    v = '0;
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    l = 0;
    for (int k = 0; k < 3; k++) l += lane(tri_normal, k) * d[k];
    // Rays parallel to the plane or leaving it on the normal's side never count.
    if (l >= 0) return v;
    num = longint'(tri_offset);
    for (int k = 0; k < 3; k++) num -= lane(tri_normal, k) * o[k];
    // Quotient magnitude in Q16.16, truncated, then saturated with the sign applied.
    n = (num < 0) ? -num : num;
    m = -l;
    half = 64'd1 << 31;
    qi = n / m;
    if (qi > (half >> 16)) mag = half;
    else mag = (qi << 16) + ((n % m) << 16) / m;
    if (num < 0) t = (mag > half - 1) ? longint'(half - 1) : longint'(mag);
    else t = (mag >= half) ? -longint'(half) : -longint'(mag);
    if (!(longint'(r.tmin) < t && t < longint'(r.tmax))) return v;
    // Hit point with 16 fraction bits; the low part of t*dir is floored.
    tlo = t & 64'hFFFF;
    thi = (t - tlo) / 65536;
    for (int k = 0; k < 3; k++) begin
      hp = clip(thi * d[k], 64'sd1 << 32) * 256;
      lp = tlo * d[k];
      if (lp < 0 && lp % 256 != 0) lp = lp / 256 - 1;
      else lp = lp / 256;
      p[k] = clip(o[k] * 256 + hp + lp, 64'sd1 << 39);
    end
    if (edge_clear(p, tri_va, tri_nab) && edge_clear(p, tri_vb, tri_nbc) &&
        edge_clear(p, tri_vc, tri_nca)) begin
      v.hit = 1'b1;
      v.t_hit = t[31:0];
    end
    return v;
  endfunction

  // Mostly short gaps, now and then a long one; none at all in a calm phase.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Input driver: holds each ray until its transfer, then idles for a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      in_fire = in_valid && in_ready;
      if (in_fire) expected_verdicts.push_back(trace_ray(ray_on_bus));
      if (!in_valid || in_fire) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_rays.size() > 0) begin
          ray_on_bus = pending_rays.pop_front();
          in_origin_x <= ray_on_bus.ox;
          in_origin_y <= ray_on_bus.oy;
          in_origin_z <= ray_on_bus.oz;
          in_dir_x <= ray_on_bus.dx;
          in_dir_y <= ray_on_bus.dy;
          in_dir_z <= ray_on_bus.dz;
          in_t_min <= ray_on_bus.tmin;
          in_t_max <= ray_on_bus.tmax;
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each transfer with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_fire = out_valid && out_ready;
      if (out_fire) begin
        if (expected_verdicts.size() == 0) begin
          $error("result transfer with no ray outstanding: hit=%0b t_hit=%0d",
                 out_hit, out_t_hit);
          errors++;
        end else begin
          verdict_t want;
          want = expected_verdicts.pop_front();
          if (out_hit !== want.hit) begin
            $error("hit: expected %0b, actual %0b", want.hit, out_hit);
            errors++;
          end
          if (out_t_hit !== want.t_hit) begin
            $error("t_hit: expected %0d, actual %0d", $signed(want.t_hit), out_t_hit);
            errors++;
          end
          if (want.hit) hits_seen++;
          else misses_seen++;
        end
      end
      if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_fire) take_gap <= pick_gap();
      end
    end
  end

  // Watchdog: the run is stuck if nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("tb_ray_triangle_intersect NOT OK");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [3:0] idx, input logic [47:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    unique case (idx)
      rti_pkg::REG_PLANE_NORMAL: tri_normal = data;
      rti_pkg::REG_PLANE_OFFSET: tri_offset = data[31:0];
      rti_pkg::REG_VERTEX_A:     tri_va = data;
      rti_pkg::REG_VERTEX_B:     tri_vb = data;
      rti_pkg::REG_VERTEX_C:     tri_vc = data;
      rti_pkg::REG_INWARD_AB:    tri_nab = data;
      rti_pkg::REG_INWARD_BC:    tri_nbc = data;
      rti_pkg::REG_INWARD_CA:    tri_nca = data;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [47:0] pack3(input int x, input int y, input int z);
    logic [15:0] a, b, c;
    a = 16'(x); b = 16'(y); c = 16'(z);
    return {c, b, a};
  endfunction

  // Waits until every ray has produced its result and the pipeline has drained.
  task automatic drain();
    while (pending_rays.size() > 0 || in_valid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  // Inward normal of edge p->q within the plane, pointing toward vertex r.
  task automatic edge_normal(input int p, input int q, input int r, output int nrm[3]);
    int u, w, s;
    u = (plane_axis + 1) % 3;
    w = (plane_axis + 2) % 3;
    nrm[plane_axis] = 0;
    nrm[u] = -(vtx[q][w] - vtx[p][w]);
    nrm[w] = vtx[q][u] - vtx[p][u];
    s = (vtx[r][u] - vtx[p][u]) * nrm[u] + (vtx[r][w] - vtx[p][w]) * nrm[w];
    if (s < 0) begin
      nrm[u] = -nrm[u];
      nrm[w] = -nrm[w];
    end
  endtask

  // Programs a random triangle lying in a plane normal to one axis.
  task automatic load_axis_triangle();
    int nab[3], nbc[3], nca[3], nv[3], u, w, area;
    plane_axis = $urandom_range(2);
    plane_sign = $urandom_range(1) ? 1 : -1;
    plane_level = $signed($urandom_range(2048)) - 1024;
    u = (plane_axis + 1) % 3;
    w = (plane_axis + 2) % 3;
    do begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) vtx[i][k] = $signed($urandom_range(2048)) - 1024;
        vtx[i][plane_axis] = plane_level;
      end
      area = (vtx[1][u] - vtx[0][u]) * (vtx[2][w] - vtx[0][w]) -
             (vtx[1][w] - vtx[0][w]) * (vtx[2][u] - vtx[0][u]);
    end while (area == 0);
    edge_normal(0, 1, 2, nab);
    edge_normal(1, 2, 0, nbc);
    edge_normal(2, 0, 1, nca);
    nv = '{0, 0, 0};
    nv[plane_axis] = 256 * plane_sign;
    write_reg(rti_pkg::REG_PLANE_NORMAL, pack3(nv[0], nv[1], nv[2]));
    write_reg(rti_pkg::REG_PLANE_OFFSET, 48'($signed(256 * plane_sign * plane_level)));
    write_reg(rti_pkg::REG_VERTEX_A, pack3(vtx[0][0], vtx[0][1], vtx[0][2]));
    write_reg(rti_pkg::REG_VERTEX_B, pack3(vtx[1][0], vtx[1][1], vtx[1][2]));
    write_reg(rti_pkg::REG_VERTEX_C, pack3(vtx[2][0], vtx[2][1], vtx[2][2]));
    write_reg(rti_pkg::REG_INWARD_AB, pack3(nab[0], nab[1], nab[2]));
    write_reg(rti_pkg::REG_INWARD_BC, pack3(nbc[0], nbc[1], nbc[2]));
    write_reg(rti_pkg::REG_INWARD_CA, pack3(nca[0], nca[1], nca[2]));
    end_writes();
  endtask

  // A ray from the normal's side toward a point of the triangle (t = 1, 2 or 4).
  // Zero weights put the point on an edge or a corner.
  task automatic aim_ray(input int wa, input int wb, input int wc, input int shift,
                         input int tlow, input int thigh);
    rti_pkg::ray_t r;
    int tgt[3], org[3], sum;
    sum = wa + wb + wc;
    if (sum == 0) begin
      wa = 1;
      sum = 1;
    end
    for (int k = 0; k < 3; k++) begin
      tgt[k] = (wa * vtx[0][k] + wb * vtx[1][k] + wc * vtx[2][k]) / sum;
      org[k] = $signed($urandom_range(2048)) - 1024;
    end
    org[plane_axis] = plane_level + plane_sign * $signed($urandom_range(1024, 1));
    r.ox = 16'(org[0]); r.oy = 16'(org[1]); r.oz = 16'(org[2]);
    r.dx = 16'((tgt[0] - org[0]) >>> shift);
    r.dy = 16'((tgt[1] - org[1]) >>> shift);
    r.dz = 16'((tgt[2] - org[2]) >>> shift);
    r.tmin = tlow;
    r.tmax = thigh;
    pending_rays.push_back(r);
  endtask

  task automatic push_raw(input int ox, input int oy, input int oz, input int dx,
                          input int dy, input int dz, input int tlow, input int thigh);
    rti_pkg::ray_t r;
    r.ox = 16'(ox); r.oy = 16'(oy); r.oz = 16'(oz);
    r.dx = 16'(dx); r.dy = 16'(dy); r.dz = 16'(dz);
    r.tmin = tlow; r.tmax = thigh;
    pending_rays.push_back(r);
  endtask

  task automatic push_noise_ray();
    push_raw($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom);
  endtask

  task automatic push_phase_rays(input bit aimed, input bit hold_midway);
    int tlow, thigh, mode;
    for (int i = 0; i < RAYS_PER_PHASE; i++) begin
      if (hold_midway && i == RAYS_PER_PHASE / 2) drain();
      mode = $urandom_range(99);
      if (!aimed || mode < 20) begin
        push_noise_ray();
      end else begin
        // Bounds mostly around the hit, sometimes tight or cutting it off.
        tlow = (mode < 70) ? -$signed($urandom_range(65536)) : $urandom_range(300000);
        thigh = (mode < 85) ? 32'sh7fffffff : $urandom_range(300000);
        aim_ray($urandom_range(255), $urandom_range(255), $urandom_range(255),
                $urandom_range(2), tlow, thigh);
      end
    end
  endtask

  initial begin
    tri_normal = '0; tri_offset = '0; tri_va = '0; tri_vb = '0; tri_vc = '0;
    tri_nab = '0; tri_nbc = '0; tri_nca = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. With the reset triangle every ray is parallel to a zero normal.
    push_raw(0, 0, 0, 0, 0, 0, 32'sh80000000, 32'sh7fffffff);
    push_raw(32767, -32768, 32767, -32768, 32767, -32768, 32'sh80000000, 32'sh7fffffff);
    drain();

    calm = 1'b1;
    load_axis_triangle();
    aim_ray(1, 1, 1, 0, 0, 32'sh7fffffff);             // centroid, plain hit
    aim_ray(1, 1, 1, 2, -65536, 32'sh7fffffff);        // shorter direction, t = 4
    aim_ray(1, 1, 0, 0, 0, 32'sh7fffffff);             // toward the midpoint of edge AB
    aim_ray(0, 1, 1, 0, 0, 32'sh7fffffff);             // toward the midpoint of edge BC
    aim_ray(1, 0, 0, 0, 0, 32'sh7fffffff);             // on a corner
    aim_ray(1, 1, 1, 0, 65536, 32'sh7fffffff);         // t equal to the lower bound
    aim_ray(1, 1, 1, 0, 0, 65536);                     // t equal to the upper bound
    aim_ray(1, 1, 1, 0, 32'sh7fffffff, 32'sh80000000); // empty bounds
    aim_ray(1, 1, 1, 0, 5, 5);                         // empty bounds, equal
    push_raw(0, 0, 0, 256, 256, 256, 32'sh80000000, 32'sh7fffffff); // same side or parallel
    push_raw(0, 0, 0, -256, -256, -256, 32'sh80000000, 32'sh7fffffff);
    push_raw(0, 0, 0, 0, 0, 0, 32'sh80000000, 32'sh7fffffff);
    // Quotient saturation in both directions: far origins with a grazing direction.
    push_raw(32767, 32767, 32767, -1, -1, -1, 32'sh80000000, 32'sh7fffffff);
    push_raw(-32768, -32768, -32768, -1, -1, -1, 32'sh80000000, 32'sh7fffffff);
    push_raw(-32768, -32768, -32768, 1, 1, 1, 32'sh80000000, 32'sh7fffffff);
    push_raw(32767, 32767, 32767, 32767, 32767, 32767, 32'sh7fffffff, 32'sh80000000);
    push_raw(-32768, -32768, -32768, -32768, -32768, -32768, 0, 32'sh7fffffff);
    drain();

    // A write to an index past the last register must leave the triangle alone.
    write_reg(REG_SPARE + 4'($urandom_range(7)), 48'($urandom));
    end_writes();
    aim_ray(1, 1, 1, 0, 0, 32'sh7fffffff);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph % 4 == 3);
      if (ph == 4) begin
        // Register extremes, then random rays against them.
        write_reg(rti_pkg::REG_PLANE_NORMAL, 48'h8000_7fff_8000);
        write_reg(rti_pkg::REG_PLANE_OFFSET, 48'h0000_7fff_ffff);
        write_reg(rti_pkg::REG_VERTEX_A, 48'hffff_ffff_ffff);
        write_reg(rti_pkg::REG_VERTEX_B, 48'h7fff_7fff_7fff);
        write_reg(rti_pkg::REG_VERTEX_C, 48'h8000_8000_8000);
        write_reg(rti_pkg::REG_INWARD_AB, 48'h7fff_8000_7fff);
        write_reg(rti_pkg::REG_INWARD_BC, 48'h0000_0000_0000);
        write_reg(rti_pkg::REG_INWARD_CA, 48'h8000_8000_8000);
        write_reg(rti_pkg::REG_PLANE_OFFSET, 48'h0000_8000_0000);
        end_writes();
        push_phase_rays(1'b0, 1'b0);
      end else if (ph % 3 == 2) begin
        // Fully random registers: mostly misses, but every bit gets exercised.
        for (int i = 0; i < 8; i++) write_reg(4'(i), 48'({$urandom, $urandom}));
        end_writes();
        push_phase_rays(1'b0, 1'b0);
      end else begin
        load_axis_triangle();
        push_phase_rays(1'b1, ph == 1);
      end
      drain();
    end

    if (expected_verdicts.size() != 0) begin
      $error("%0d results never arrived", expected_verdicts.size());
      errors++;
    end
    $display("Checked %0d hits and %0d misses over %0d triangle settings,",
             hits_seen, misses_seen, PHASES + 2);
    $display("with random idle gaps on both channels and %0d mismatches.", errors);
    if (errors == 0) begin
      $display("tb_ray_triangle_intersect OK");
    end else begin
      $display("tb_ray_triangle_intersect NOT OK");
    end
    $finish;
  end

endmodule
